[rtl/cmp_pkg.sv]
// compact miller projection: shared types, constants and microcode
// no dependencies; used by every other file of the block
`default_nettype none

package cmp_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 28;
    localparam int WIDE_W    = 64;
    localparam int PROD_W    = 2 * WIDE_W;
    localparam int HALF_W    = WIDE_W / 2;
    localparam int LIMIT_W   = 7;
    localparam int TOL_W     = 8;
    localparam int CFG_W     = 8;
    localparam int PC_W      = 4;
    localparam int MCNT_W    = 3;
    localparam int DCNT_W    = 7;
    localparam int Q60_BITS  = 60;

    localparam logic [MCNT_W-1:0] MUL_STEPS = MCNT_W'(4);
    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(WIDE_W);

    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [WIDE_W:0]    ext_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);
    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(1);

    localparam logic CFG_LIMIT = 1'b0;
    localparam logic CFG_TOL   = 1'b1;

    localparam wide_t INT_MAX   = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam wide_t COORD_MAX = wide_t'({1'b0, {(COORD_W-1){1'b1}}});
    localparam wide_t COORD_MIN = -COORD_MAX - wide_t'(1);
    localparam ext_t  EXT_MAX   = ext_t'(INT_MAX);
    localparam ext_t  EXT_MIN   = -EXT_MAX;
    localparam ext_t  EXT_CMAX  = ext_t'(COORD_MAX);
    localparam ext_t  EXT_CMIN  = ext_t'(COORD_MIN);

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    // polynomial coefficients, rounded half up to the fraction width
    localparam logic [PROD_W-1:0] K1_MAG =
        ((PROD_W'(9902) << FRAC_BITS) + PROD_W'(5000)) / PROD_W'(10000);
    localparam logic [PROD_W-1:0] K2_MAG =
        ((PROD_W'(1604) << FRAC_BITS) + PROD_W'(5000)) / PROD_W'(10000);
    localparam logic [PROD_W-1:0] K3_MAG =
        ((PROD_W'(3054) << FRAC_BITS) + PROD_W'(50000)) / PROD_W'(100000);
    localparam logic [PROD_W-1:0] C2_MAG =
        ((PROD_W'(4812) << FRAC_BITS) + PROD_W'(5000)) / PROD_W'(10000);
    localparam logic [PROD_W-1:0] C3_MAG =
        ((PROD_W'(15270) << FRAC_BITS) + PROD_W'(50000)) / PROD_W'(100000);

    localparam wide_t K1_Q = wide_t'(K1_MAG[WIDE_W-1:0]);
    localparam wide_t K2_Q = wide_t'(K2_MAG[WIDE_W-1:0]);
    localparam wide_t K3_Q = -wide_t'(K3_MAG[WIDE_W-1:0]);
    localparam wide_t C2_Q = wide_t'(C2_MAG[WIDE_W-1:0]);
    localparam wide_t C3_Q = -wide_t'(C3_MAG[WIDE_W-1:0]);

    // y clamp: pi in q60 times the scale factor, then rounded to the fraction width
    localparam logic [WIDE_W-1:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [PROD_W-1:0] MAXY_PROD =
        PROD_W'(PI_Q60) * PROD_W'(64'd6000207669862655);
    localparam logic [PROD_W-1:0] MAXY_Q60 =
        (MAXY_PROD + PROD_W'(64'd5000000000000000)) / PROD_W'(64'd10000000000000000);
    localparam logic [PROD_W-1:0] MAXY_MAG =
        (MAXY_Q60 + (PROD_W'(1) << (Q60_BITS - FRAC_BITS - 1))) >> (Q60_BITS - FRAC_BITS);
    localparam wide_t MAXY_Q = wide_t'(MAXY_MAG[WIDE_W-1:0]);

    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_SUBSAT,
        OP_DIV
    } op_t;

    typedef enum logic [3:0] {
        SRC_RES,
        SRC_V2,
        SRC_T,
        SRC_F,
        SRC_Y,
        SRC_STEP,
        SRC_ZERO,
        SRC_K1,
        SRC_K2,
        SRC_K3,
        SRC_C2,
        SRC_C3
    } src_t;

    typedef enum logic [2:0] {
        DST_V2,
        DST_T,
        DST_F,
        DST_STEP,
        DST_RES
    } dst_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        dst_t dst;
    } uop_t;

    localparam logic [PC_W-1:0] PC_START    = PC_W'(0);
    localparam logic [PC_W-1:0] PC_POLY_END = PC_W'(5);
    localparam logic [PC_W-1:0] PC_STEP     = PC_W'(12);
    localparam logic [PC_W-1:0] PC_FWD_SAT  = PC_W'(13);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic count;
        logic emit;
        logic nc;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic inverse;
        logic limit_zero;
        logic at_limit;
        logic small_step;
        logic out_free;
    } stat_t;

    function automatic logic [WIDE_W-1:0] mag(input wide_t v);
        logic [WIDE_W-1:0] u;
        u = v;
        return v[WIDE_W-1] ? (~u + 1'b1) : u;
    endfunction

    // polynomial, residual, derivative, newton step; forward ends with saturation
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            4'd0:    u = '{op: OP_MUL, a: SRC_RES, b: SRC_RES, dst: DST_V2};
            4'd1:    u = '{op: OP_MUL, a: SRC_K3, b: SRC_V2, dst: DST_T};
            4'd2:    u = '{op: OP_ADD, a: SRC_K2, b: SRC_T, dst: DST_T};
            4'd3:    u = '{op: OP_MUL, a: SRC_V2, b: SRC_T, dst: DST_T};
            4'd4:    u = '{op: OP_ADD, a: SRC_K1, b: SRC_T, dst: DST_T};
            4'd5:    u = '{op: OP_MUL, a: SRC_RES, b: SRC_T, dst: DST_T};
            4'd6:    u = '{op: OP_SUB, a: SRC_T, b: SRC_Y, dst: DST_F};
            4'd7:    u = '{op: OP_MUL, a: SRC_C3, b: SRC_V2, dst: DST_T};
            4'd8:    u = '{op: OP_ADD, a: SRC_C2, b: SRC_T, dst: DST_T};
            4'd9:    u = '{op: OP_MUL, a: SRC_V2, b: SRC_T, dst: DST_T};
            4'd10:   u = '{op: OP_ADD, a: SRC_K1, b: SRC_T, dst: DST_T};
            4'd11:   u = '{op: OP_DIV, a: SRC_F, b: SRC_T, dst: DST_STEP};
            4'd12:   u = '{op: OP_SUBSAT, a: SRC_RES, b: SRC_STEP, dst: DST_RES};
            4'd13:   u = '{op: OP_SUBSAT, a: SRC_T, b: SRC_ZERO, dst: DST_RES};
            default: u = '{op: OP_ADD, a: SRC_ZERO, b: SRC_ZERO, dst: DST_F};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[rtl/cmp_channels.sv]
// compact miller projection: input and output channel interfaces
// depends on cmp_pkg
`default_nettype none

interface cmp_in_if;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    cmp_pkg::coord_t      first_coord;
    cmp_pkg::coord_t      second_coord;

    modport source (output valid, operation, first_coord, second_coord, input ready);
    modport sink (input valid, operation, first_coord, second_coord, output ready);
endinterface

interface cmp_out_if;
    logic                          valid;
    logic                          ready;
    cmp_pkg::coord_t               first_result;
    cmp_pkg::coord_t               second_result;
    logic                          not_converged;
    logic [cmp_pkg::LIMIT_W-1:0]   iterations_used;

    modport source (output valid, first_result, second_result, not_converged,
                    iterations_used, input ready);
    modport sink (input valid, first_result, second_result, not_converged,
                  iterations_used, output ready);
endinterface

`default_nettype wire

[rtl/cmp_mul.sv]
// compact miller projection: fixed-point multiplier, four 32x32 partial products
// depends on cmp_pkg
`default_nettype none

module cmp_mul (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  cmp_pkg::wide_t      a,
    input  cmp_pkg::wide_t      b,
    output logic                done,
    output cmp_pkg::wide_t      result
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [cmp_pkg::MCNT_W-1:0]        cnt_reg;
    logic [cmp_pkg::WIDE_W-1:0]        ma_reg;
    logic [cmp_pkg::WIDE_W-1:0]        mb_reg;
    logic                              neg_reg;
    logic [cmp_pkg::PROD_W-1:0]        acc_reg;
    cmp_pkg::wide_t                    result_reg;

    logic [cmp_pkg::HALF_W-1:0]        a_half;
    logic [cmp_pkg::HALF_W-1:0]        b_half;
    logic [cmp_pkg::WIDE_W-1:0]        part;
    logic [6:0]                        shift;
    logic [cmp_pkg::PROD_W-1:0]        acc_next;
    logic [cmp_pkg::PROD_W-1:0]        rnd;
    logic [cmp_pkg::WIDE_W-1:0]        m;
    logic [cmp_pkg::WIDE_W-1:0]        m_sat;
    cmp_pkg::wide_t                    result_next;

    always_comb
    begin
        a_half   = cnt_reg[1] ? ma_reg[cmp_pkg::WIDE_W-1:cmp_pkg::HALF_W]
                              : ma_reg[cmp_pkg::HALF_W-1:0];
        b_half   = cnt_reg[0] ? mb_reg[cmp_pkg::WIDE_W-1:cmp_pkg::HALF_W]
                              : mb_reg[cmp_pkg::HALF_W-1:0];
        part     = cmp_pkg::WIDE_W'(a_half) * cmp_pkg::WIDE_W'(b_half);
        shift    = 7'((2'(cnt_reg[1]) + 2'(cnt_reg[0])) * cmp_pkg::HALF_W);
        acc_next = acc_reg + (cmp_pkg::PROD_W'(part) << shift);
        rnd      = acc_reg + cmp_pkg::ROUND_HALF;
        m        = rnd[cmp_pkg::FRAC_BITS+cmp_pkg::WIDE_W-1:cmp_pkg::FRAC_BITS];
        if ((|rnd[cmp_pkg::PROD_W-1:cmp_pkg::FRAC_BITS+cmp_pkg::WIDE_W])
            || m[cmp_pkg::WIDE_W-1])
        begin
            m_sat = cmp_pkg::INT_MAX;
        end
        else
        begin
            m_sat = m;
        end
        result_next = neg_reg ? -cmp_pkg::wide_t'(m_sat) : cmp_pkg::wide_t'(m_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == cmp_pkg::MUL_STEPS)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= cmp_pkg::mag(a);
            mb_reg  <= cmp_pkg::mag(b);
            neg_reg <= a[cmp_pkg::WIDE_W-1] ^ b[cmp_pkg::WIDE_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == cmp_pkg::MUL_STEPS)
            begin
                result_reg <= result_next;
            end
            else
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/cmp_div.sv]
// compact miller projection: restoring fixed-point divider, one quotient bit a cycle
// depends on cmp_pkg
`default_nettype none

module cmp_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  cmp_pkg::wide_t      a,
    input  cmp_pkg::wide_t      b,
    output logic                done,
    output cmp_pkg::wide_t      result
);

    logic                              busy_reg;
    logic                              check_reg;
    logic                              done_reg;
    logic [cmp_pkg::DCNT_W-1:0]        cnt_reg;
    logic [cmp_pkg::WIDE_W-1:0]        rem_reg;
    logic [cmp_pkg::WIDE_W-1:0]        lo_reg;
    logic [cmp_pkg::WIDE_W-1:0]        q_reg;
    logic [cmp_pkg::WIDE_W-1:0]        d_reg;
    logic                              neg_reg;
    cmp_pkg::wide_t                    result_reg;

    logic [cmp_pkg::WIDE_W-1:0]        ma;
    logic [cmp_pkg::WIDE_W:0]          rs;
    logic [cmp_pkg::WIDE_W:0]          diff;
    logic                              ge;
    logic                              up;
    logic [cmp_pkg::WIDE_W-1:0]        qr;
    logic [cmp_pkg::WIDE_W-1:0]        qs;
    logic                              d_zero;
    logic                              ovf;

    always_comb
    begin
        ma     = cmp_pkg::mag(a);
        rs     = {rem_reg, lo_reg[cmp_pkg::WIDE_W-1]};
        diff   = rs - {1'b0, d_reg};
        ge     = rs >= {1'b0, d_reg};
        up     = ({rem_reg, 1'b0} >= {1'b0, d_reg}) && (q_reg < cmp_pkg::INT_MAX);
        qr     = q_reg + cmp_pkg::WIDE_W'(up);
        qs     = (qr > cmp_pkg::INT_MAX) ? cmp_pkg::INT_MAX : qr;
        d_zero = (d_reg == '0);
        ovf    = (rem_reg >= d_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            check_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                check_reg <= 1'b1;
                cnt_reg   <= '0;
            end
            else if (busy_reg)
            begin
                if (check_reg)
                begin
                    check_reg <= 1'b0;
                    if (d_zero || ovf)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else if (cnt_reg == cmp_pkg::DIV_STEPS)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= ma >> (cmp_pkg::WIDE_W - cmp_pkg::FRAC_BITS);
            lo_reg  <= ma << cmp_pkg::FRAC_BITS;
            d_reg   <= cmp_pkg::mag(b);
            neg_reg <= a[cmp_pkg::WIDE_W-1] ^ b[cmp_pkg::WIDE_W-1];
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (check_reg)
            begin
                if (d_zero)
                begin
                    result_reg <= '0;
                end
                else if (ovf)
                begin
                    result_reg <= neg_reg ? -cmp_pkg::INT_MAX : cmp_pkg::INT_MAX;
                end
            end
            else if (cnt_reg == cmp_pkg::DIV_STEPS)
            begin
                result_reg <= neg_reg ? -cmp_pkg::wide_t'(qs) : cmp_pkg::wide_t'(qs);
            end
            else
            begin
                rem_reg <= ge ? diff[cmp_pkg::WIDE_W-1:0] : rs[cmp_pkg::WIDE_W-1:0];
                lo_reg  <= lo_reg << 1;
                q_reg   <= {q_reg[cmp_pkg::WIDE_W-2:0], ge};
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/cmp_datapath.sv]
// compact miller projection: operand registers, saturating adder, mul and div units,
// configuration and result registers; depends on cmp_pkg, cmp_channels, cmp_mul, cmp_div
`default_nettype none

module cmp_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       din_operation,
    input  cmp_pkg::coord_t                 din_first,
    input  cmp_pkg::coord_t                 din_second,
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_index,
    input  wire logic [cmp_pkg::CFG_W-1:0]  cfg_data,
    input  cmp_pkg::cmd_t                   cmd,
    output cmp_pkg::stat_t                  status,
    cmp_out_if.source                       dout
);

    cmp_pkg::coord_t                  first_reg;
    logic                             op_reg;
    cmp_pkg::wide_t                   y_reg;
    cmp_pkg::wide_t                   res_reg;
    cmp_pkg::wide_t                   v2_reg;
    cmp_pkg::wide_t                   t_reg;
    cmp_pkg::wide_t                   f_reg;
    cmp_pkg::wide_t                   step_reg;
    cmp_pkg::dst_t                    dst_reg;
    logic                             alu_done_reg;
    logic [cmp_pkg::LIMIT_W-1:0]      used_reg;
    logic [cmp_pkg::LIMIT_W-1:0]      limit_reg;
    logic [cmp_pkg::TOL_W-1:0]        tol_reg;
    logic                             out_valid_reg;
    cmp_pkg::coord_t                  out_first_reg;
    cmp_pkg::coord_t                  out_second_reg;
    logic                             out_nc_reg;
    logic [cmp_pkg::LIMIT_W-1:0]      out_used_reg;

    cmp_pkg::wide_t                   opa;
    cmp_pkg::wide_t                   opb;
    cmp_pkg::ext_t                    sum;
    cmp_pkg::ext_t                    diff;
    cmp_pkg::wide_t                   alu_out;
    cmp_pkg::wide_t                   sec_ext;
    cmp_pkg::wide_t                   sec_clamp;
    logic                             alu_issue;
    logic                             mul_start;
    logic                             div_start;
    logic                             mul_done;
    logic                             div_done;
    cmp_pkg::wide_t                   mul_result;
    cmp_pkg::wide_t                   div_result;
    logic                             wr_en;
    cmp_pkg::dst_t                    wr_dst;
    cmp_pkg::wide_t                   wr_data;

    function automatic cmp_pkg::wide_t pick(
        input cmp_pkg::src_t  s,
        input cmp_pkg::wide_t res,
        input cmp_pkg::wide_t v2,
        input cmp_pkg::wide_t t,
        input cmp_pkg::wide_t f,
        input cmp_pkg::wide_t y,
        input cmp_pkg::wide_t step
    );
        cmp_pkg::wide_t v;
        case (s)
            cmp_pkg::SRC_RES:  v = res;
            cmp_pkg::SRC_V2:   v = v2;
            cmp_pkg::SRC_T:    v = t;
            cmp_pkg::SRC_F:    v = f;
            cmp_pkg::SRC_Y:    v = y;
            cmp_pkg::SRC_STEP: v = step;
            cmp_pkg::SRC_K1:   v = cmp_pkg::K1_Q;
            cmp_pkg::SRC_K2:   v = cmp_pkg::K2_Q;
            cmp_pkg::SRC_K3:   v = cmp_pkg::K3_Q;
            cmp_pkg::SRC_C2:   v = cmp_pkg::C2_Q;
            cmp_pkg::SRC_C3:   v = cmp_pkg::C3_Q;
            default:           v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa  = pick(cmd.uop.a, res_reg, v2_reg, t_reg, f_reg, y_reg, step_reg);
        opb  = pick(cmd.uop.b, res_reg, v2_reg, t_reg, f_reg, y_reg, step_reg);
        sum  = cmp_pkg::ext_t'(opa) + cmp_pkg::ext_t'(opb);
        diff = cmp_pkg::ext_t'(opa) - cmp_pkg::ext_t'(opb);
        case (cmd.uop.op)
            cmp_pkg::OP_SUB:
            begin
                if (diff > cmp_pkg::EXT_MAX)
                    alu_out = cmp_pkg::INT_MAX;
                else if (diff < cmp_pkg::EXT_MIN)
                    alu_out = -cmp_pkg::INT_MAX;
                else
                    alu_out = diff[cmp_pkg::WIDE_W-1:0];
            end
            cmp_pkg::OP_SUBSAT:
            begin
                if (diff > cmp_pkg::EXT_CMAX)
                    alu_out = cmp_pkg::COORD_MAX;
                else if (diff < cmp_pkg::EXT_CMIN)
                    alu_out = cmp_pkg::COORD_MIN;
                else
                    alu_out = diff[cmp_pkg::WIDE_W-1:0];
            end
            default:
            begin
                if (sum > cmp_pkg::EXT_MAX)
                    alu_out = cmp_pkg::INT_MAX;
                else if (sum < cmp_pkg::EXT_MIN)
                    alu_out = -cmp_pkg::INT_MAX;
                else
                    alu_out = sum[cmp_pkg::WIDE_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        sec_ext = cmp_pkg::wide_t'(din_second);
        if (sec_ext > cmp_pkg::MAXY_Q)
            sec_clamp = cmp_pkg::MAXY_Q;
        else if (sec_ext < -cmp_pkg::MAXY_Q)
            sec_clamp = -cmp_pkg::MAXY_Q;
        else
            sec_clamp = sec_ext;
    end

    assign mul_start = cmd.issue && (cmd.uop.op == cmp_pkg::OP_MUL);
    assign div_start = cmd.issue && (cmd.uop.op == cmp_pkg::OP_DIV);
    assign alu_issue = cmd.issue && !mul_start && !div_start;

    cmp_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (opa),
        .b      (opb),
        .done   (mul_done),
        .result (mul_result)
    );

    cmp_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .a      (opa),
        .b      (opb),
        .done   (div_done),
        .result (div_result)
    );

    always_comb
    begin
        wr_en   = 1'b0;
        wr_dst  = dst_reg;
        wr_data = alu_out;
        if (alu_issue)
        begin
            wr_en  = 1'b1;
            wr_dst = cmd.uop.dst;
        end
        else if (mul_done)
        begin
            wr_en   = 1'b1;
            wr_data = mul_result;
        end
        else if (div_done)
        begin
            wr_en   = 1'b1;
            wr_data = div_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg <= din_first;
            op_reg    <= din_operation;
            y_reg     <= sec_clamp;
            res_reg   <= din_operation ? sec_clamp : sec_ext;
        end
        else if (wr_en)
        begin
            case (wr_dst)
                cmp_pkg::DST_V2:   v2_reg   <= wr_data;
                cmp_pkg::DST_T:    t_reg    <= wr_data;
                cmp_pkg::DST_F:    f_reg    <= wr_data;
                cmp_pkg::DST_STEP: step_reg <= wr_data;
                cmp_pkg::DST_RES:  res_reg  <= wr_data;
                default:           t_reg    <= wr_data;
            endcase
        end
        if (cmd.issue)
        begin
            dst_reg <= cmd.uop.dst;
        end
        if (cmd.emit)
        begin
            out_first_reg  <= first_reg;
            out_second_reg <= res_reg[cmp_pkg::COORD_W-1:0];
            out_nc_reg     <= cmd.nc;
            out_used_reg   <= used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alu_done_reg  <= 1'b0;
            used_reg      <= '0;
            limit_reg     <= cmp_pkg::LIMIT_RESET;
            tol_reg       <= cmp_pkg::TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            alu_done_reg <= alu_issue;
            if (cmd.load)
                used_reg <= '0;
            else if (cmd.count)
                used_reg <= used_reg + 1'b1;
            if (cfg_write)
            begin
                case (cfg_index)
                    cmp_pkg::CFG_LIMIT: limit_reg <= cfg_data[cmp_pkg::LIMIT_W-1:0];
                    cmp_pkg::CFG_TOL:   tol_reg   <= cfg_data[cmp_pkg::TOL_W-1:0];
                    default:            tol_reg   <= tol_reg;
                endcase
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.done       = alu_done_reg || mul_done || div_done;
        status.inverse    = op_reg;
        status.limit_zero = (limit_reg == '0);
        status.at_limit   = (used_reg == limit_reg);
        status.small_step = cmp_pkg::mag(step_reg) < cmp_pkg::WIDE_W'(tol_reg);
        status.out_free   = !out_valid_reg || dout.ready;
    end

    assign dout.valid           = out_valid_reg;
    assign dout.first_result    = out_first_reg;
    assign dout.second_result   = out_second_reg;
    assign dout.not_converged   = out_nc_reg;
    assign dout.iterations_used = out_used_reg;

`ifndef NO_ASSERTIONS
    a_single_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");

    a_forward_no_iter: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !op_reg) |-> (used_reg == '0))
        else $error("forward transaction reports iterations");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (res_reg <= cmp_pkg::COORD_MAX && res_reg >= cmp_pkg::COORD_MIN))
        else $error("result outside coordinate range");
`endif

endmodule

`default_nettype wire

[rtl/cmp_ctrl.sv]
// compact miller projection: sequencer stepping the microcode and newton loop
// depends on cmp_pkg
`default_nettype none

module cmp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  cmp_pkg::stat_t     status,
    output logic               in_ready,
    output cmp_pkg::cmd_t      cmd
);

    cmp_pkg::state_t               state_reg;
    cmp_pkg::state_t               state_next;
    logic [cmp_pkg::PC_W-1:0]      pc_reg;
    logic [cmp_pkg::PC_W-1:0]      pc_next;
    logic                          nc_reg;
    logic                          nc_next;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        nc_next    = nc_reg;
        case (state_reg)
            cmp_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = cmp_pkg::ST_START;
            end
            cmp_pkg::ST_START:
            begin
                pc_next = cmp_pkg::PC_START;
                if (status.inverse && status.limit_zero)
                begin
                    nc_next    = 1'b1;
                    state_next = cmp_pkg::ST_DONE;
                end
                else
                begin
                    nc_next    = 1'b0;
                    state_next = cmp_pkg::ST_ISSUE;
                end
            end
            cmp_pkg::ST_ISSUE:
            begin
                state_next = cmp_pkg::ST_WAIT;
            end
            cmp_pkg::ST_WAIT:
            begin
                if (status.done)
                begin
                    if (pc_reg == cmp_pkg::PC_POLY_END && !status.inverse)
                    begin
                        pc_next    = cmp_pkg::PC_FWD_SAT;
                        state_next = cmp_pkg::ST_ISSUE;
                    end
                    else if (pc_reg == cmp_pkg::PC_FWD_SAT)
                    begin
                        state_next = cmp_pkg::ST_DONE;
                    end
                    else if (pc_reg == cmp_pkg::PC_STEP)
                    begin
                        if (status.small_step)
                        begin
                            nc_next    = 1'b0;
                            state_next = cmp_pkg::ST_DONE;
                        end
                        else if (status.at_limit)
                        begin
                            nc_next    = 1'b1;
                            state_next = cmp_pkg::ST_DONE;
                        end
                        else
                        begin
                            pc_next    = cmp_pkg::PC_START;
                            state_next = cmp_pkg::ST_ISSUE;
                        end
                    end
                    else
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = cmp_pkg::ST_ISSUE;
                    end
                end
            end
            cmp_pkg::ST_DONE:
            begin
                if (status.out_free)
                    state_next = cmp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cmp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == cmp_pkg::ST_IDLE);
        cmd.load  = (state_reg == cmp_pkg::ST_IDLE) && in_valid;
        cmd.issue = (state_reg == cmp_pkg::ST_ISSUE);
        cmd.count = (state_reg == cmp_pkg::ST_ISSUE) && (pc_reg == cmp_pkg::PC_STEP);
        cmd.emit  = (state_reg == cmp_pkg::ST_DONE) && status.out_free;
        cmd.nc    = nc_reg;
        cmd.uop   = cmp_pkg::ucode(pc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmp_pkg::ST_IDLE;
            pc_reg    <= cmp_pkg::PC_START;
            nc_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            nc_reg    <= nc_next;
        end
    end

endmodule

`default_nettype wire

[rtl/compact_miller_projection.sv]
// compact miller projection top level: sequencer plus datapath
// depends on cmp_pkg, cmp_channels, cmp_ctrl, cmp_datapath
`default_nettype none

// Compact Miller projection in signed Q4.28 radians, one transaction at a time.
// operation 0 maps (longitude, latitude) to (x, y); operation 1 clamps y and solves
// latitude by Newton iteration, bounded by the iteration_limit register (reset 100).
// Each iteration is dominated by the 64-step restoring divider and six passes
// through the shared 32x32 multiplier. A finished result sits in an output
// register, so the next transaction is taken while it waits. Register 0 is
// iteration_limit, register 1 step_tolerance (reset 1); write them only while
// the block is idle.
module compact_miller_projection (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    cmp_in_if.sink                          din,
    cmp_out_if.source                       dout,
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_index,
    input  wire logic [cmp_pkg::CFG_W-1:0]  cfg_data
);

    cmp_pkg::cmd_t   cmd;
    cmp_pkg::stat_t  status;
    logic            in_ready;

    cmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    cmp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .din_operation (din.operation),
        .din_first     (din.first_coord),
        .din_second    (din.second_coord),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .dout          (dout)
    );

    assign din.ready = in_ready;

endmodule

`default_nettype wire

[verif/testbench.sv]
// compact miller projection testbench: directed and random transactions in both
// directions, checked against an in-bench fixed point projection predictor
// depends on cmp_pkg, cmp_channels and the compact_miller_projection rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [63:0] SAT64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam bit OP_FORWARD = 1'b0;
    localparam bit OP_INVERSE = 1'b1;

    typedef struct {
        cmp_pkg::coord_t             lon_x;
        cmp_pkg::coord_t             lat_y;
        logic                        stalled;
        logic [cmp_pkg::LIMIT_W-1:0] steps;
    } projection_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic cfg_index = cmp_pkg::CFG_LIMIT;
    logic [cmp_pkg::CFG_W-1:0] cfg_data = '0;

    cmp_in_if  in_ch();
    cmp_out_if out_ch();

    compact_miller_projection dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (in_ch.sink),
        .dout      (out_ch.source),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    projection_t expected_q[$];
    int errors = 0;
    bit idling = 1'b1;
    logic [cmp_pkg::LIMIT_W-1:0] newton_limit = cmp_pkg::LIMIT_RESET;
    logic [cmp_pkg::TOL_W-1:0] newton_tol = cmp_pkg::TOL_RESET;

    function automatic bit [63:0] abs_of(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_of(bit [63:0] m, bit neg);
        if (m > SAT64)
            m = SAT64;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit [63:0] div_near(bit [127:0] n, bit [63:0] d);
        bit [127:0] q, r;
        if (n[127:64] >= d)
            return SAT64;
        q = n / {64'b0, d};
        r = n - q * {64'b0, d};
        if (r >= {64'b0, d} - r && q < {64'b0, SAT64})
            q = q + 1;
        if (q > {64'b0, SAT64})
            q = {64'b0, SAT64};
        return q[63:0];
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        bit [127:0] p;
        bit [63:0] m;
        p = {64'b0, abs_of(a)} * {64'b0, abs_of(b)};
        p = p + (128'd1 << (cmp_pkg::FRAC_BITS - 1));
        m = (p[127:cmp_pkg::FRAC_BITS+64] != 0) ? SAT64
                                                : p[cmp_pkg::FRAC_BITS+63:cmp_pkg::FRAC_BITS];
        return signed_of(m, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(longint a, longint b);
        if (b == 0)
            return 0;
        return signed_of(div_near({64'b0, abs_of(a)} << cmp_pkg::FRAC_BITS, abs_of(b)),
                         (a < 0) != (b < 0));
    endfunction

    function automatic longint clamp64(logic signed [64:0] s);
        if (s > $signed({2'b0, SAT64[62:0]}))
            return longint'(SAT64);
        if (s < -$signed({2'b0, SAT64[62:0]}))
            return -longint'(SAT64);
        return longint'(s[63:0]);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        return clamp64(65'(a) + 65'(b));
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        return clamp64(65'(a) - 65'(b));
    endfunction

    function automatic longint coord_sat(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint frac_const(longint num, longint den);
        return longint'(div_near(128'(num) << cmp_pkg::FRAC_BITS, 64'(den)));
    endfunction

    function automatic longint latitude_poly(longint v, longint v2);
        longint k1, k2, k3;
        k1 = frac_const(9902, 10000);
        k2 = frac_const(1604, 10000);
        k3 = -frac_const(3054, 100000);
        return fx_mul(v, add_sat(k1, fx_mul(v2, add_sat(k2, fx_mul(k3, v2)))));
    endfunction

    function automatic longint y_limit();
        bit [63:0] v;
        v = div_near(128'(64'h3243F6A8885A308D) * 128'(64'd6000207669862655),
                     64'd10000000000000000);
        return coord_sat(longint'((v + (64'd1 << 31)) >> 32));
    endfunction

    function automatic projection_t project(bit op, cmp_pkg::coord_t c1,
                                            cmp_pkg::coord_t c2);
        projection_t r;
        longint y, res, y2, f, fd, step, ylim;
        int used;
        bit done;
        used = 0;
        done = 1'b0;
        y = longint'(c2);
        if (op == OP_FORWARD)
        begin
            res = coord_sat(latitude_poly(y, fx_mul(y, y)));
            done = 1'b1;
        end
        else
        begin
            ylim = y_limit();
            if (y > ylim)
                y = ylim;
            else if (y < -ylim)
                y = -ylim;
            res = y;
            while (used < newton_limit && !done)
            begin
                y2 = fx_mul(res, res);
                f = sub_sat(latitude_poly(res, y2), y);
                fd = add_sat(frac_const(9902, 10000),
                             fx_mul(y2, add_sat(frac_const(4812, 10000),
                                                fx_mul(-frac_const(15270, 100000), y2))));
                step = fx_div(f, fd);
                res = coord_sat(sub_sat(res, step));
                used++;
                if (abs_of(step) < 64'(newton_tol))
                    done = 1'b1;
            end
        end
        r.lon_x = c1;
        r.lat_y = cmp_pkg::coord_t'(res);
        r.stalled = !done;
        r.steps = cmp_pkg::LIMIT_W'(used);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        projection_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("unexpected transaction at %0t", $realtime);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.first_result !== e.lon_x)
                    report_mismatch("first_result", out_ch.first_result, e.lon_x);
                if (out_ch.second_result !== e.lat_y)
                    report_mismatch("second_result", out_ch.second_result, e.lat_y);
                if (out_ch.not_converged !== e.stalled)
                    report_mismatch("not_converged", out_ch.not_converged, e.stalled);
                if (out_ch.iterations_used !== e.steps)
                    report_mismatch("iterations_used", out_ch.iterations_used, e.steps);
            end
        end
    end

    always @(negedge clk)
        out_ch.ready <= idling ? ($urandom_range(99) >= 20) : 1'b1;

    task automatic send_item(bit op, cmp_pkg::coord_t c1, cmp_pkg::coord_t c2);
        while (idling && $urandom_range(99) < 20)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.operation = op;
        in_ch.first_coord = c1;
        in_ch.second_coord = c2;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_q.push_back(project(op, c1, c2));
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_newton(logic [cmp_pkg::LIMIT_W-1:0] lim,
                              logic [cmp_pkg::TOL_W-1:0] tol);
        drain();
        cfg_write = 1'b1;
        cfg_index = cmp_pkg::CFG_LIMIT;
        cfg_data = cmp_pkg::CFG_W'(lim);
        @(negedge clk);
        cfg_index = cmp_pkg::CFG_TOL;
        cfg_data = tol;
        @(negedge clk);
        cfg_write = 1'b0;
        newton_limit = lim;
        newton_tol = tol;
    endtask

    function automatic cmp_pkg::coord_t rand_lat();
        if ($urandom_range(1))
            return cmp_pkg::coord_t'($urandom());
        return cmp_pkg::coord_t'($urandom_range(1013000000) - 506500000);
    endfunction

    task automatic test_forward_extremes();
        cmp_pkg::coord_t vals[8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, -1,
                                     32'sh1922_0000, -32'sh1922_0000, 32'sh3000_0000};
        foreach (vals[i])
            send_item(OP_FORWARD, vals[7 - i], vals[i]);
    endtask

    task automatic test_inverse_clamp();
        cmp_pkg::coord_t vals[8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, -1,
                                     32'sh1E2A_0000, -32'sh1E2A_0000, 32'sh0800_0000};
        foreach (vals[i])
            send_item(OP_INVERSE, vals[i], vals[7 - i]);
    endtask

    task automatic test_register_extremes();
        set_newton(7'd0, 8'd1);
        send_item(OP_INVERSE, 32'sh1234_5678, 32'sh1000_0000);
        set_newton(7'd1, 8'd255);
        send_item(OP_INVERSE, -32'sh1234_5678, 32'sh7FFF_FFFF);
        set_newton(7'd5, 8'd0);
        send_item(OP_INVERSE, 5, -32'sh0C00_0000);
        set_newton(7'd127, 8'd0);
        send_item(OP_INVERSE, 7, 32'sh0400_0000);
        set_newton(7'd127, 8'd255);
        send_item(OP_INVERSE, 9, 32'sh1800_0000);
        set_newton(cmp_pkg::LIMIT_RESET, cmp_pkg::TOL_RESET);
    endtask

    task automatic test_wait_for_results();
        send_item(OP_INVERSE, cmp_pkg::coord_t'($urandom()), rand_lat());
        send_item(OP_FORWARD, cmp_pkg::coord_t'($urandom()), rand_lat());
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        send_item(OP_INVERSE, cmp_pkg::coord_t'($urandom()), rand_lat());
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 1300; i++)
        begin
            if (i % 260 == 259)
                set_newton(cmp_pkg::LIMIT_W'($urandom_range(127, 1)),
                           cmp_pkg::TOL_W'($urandom_range(255, 1)));
            idling = !(i >= 400 && i < 700);
            send_item($urandom_range(99) < 60 ? OP_INVERSE : OP_FORWARD,
                      cmp_pkg::coord_t'($urandom()), rand_lat());
        end
        idling = 1'b1;
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.operation = OP_FORWARD;
        in_ch.first_coord = '0;
        in_ch.second_coord = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_forward_extremes();
        test_inverse_clamp();
        test_register_extremes();
        test_wait_for_results();
        test_random_mix();
        drain();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("compact_miller_projection verification clean");
        else
            $display("compact_miller_projection verification failed");
        $finish;
    end

    initial
    begin
        #1s;
        $display("compact_miller_projection verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/cmp_pkg.sv
rtl/cmp_channels.sv
rtl/cmp_mul.sv
rtl/cmp_div.sv
rtl/cmp_datapath.sv
rtl/cmp_ctrl.sv
rtl/compact_miller_projection.sv
verif/testbench.sv
